// ===== rtl/lsord_pkg.sv =====
// shared types, widths and codes for the layer stack order block
`timescale 1ns / 1ps

package lsord_pkg;

  // layer count range and default
  localparam int LAYERS_DEF = 256;
  localparam int LAYERS_MAX = 1024;

  // internal slot index and stack height widths, sized for the largest pool
  localparam int SLOT_W = $clog2(LAYERS_MAX);
  localparam int HGT_W  = SLOT_W + 2;

  // beat field widths
  localparam int MODE_W   = 2;
  localparam int LAYER_W  = 8;
  localparam int REQ_W    = 9;
  localparam int STATUS_W = 2;
  localparam int FH_W     = 9;
  localparam int VIS_W    = 9;

  localparam int IN_BITS   = MODE_W + LAYER_W + REQ_W;
  localparam int RES_BITS  = STATUS_W + LAYER_W + FH_W + VIS_W;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W = ((RES_BITS + 7) / 8) * 8;

  typedef logic [SLOT_W-1:0]        slot_t;
  typedef logic signed [HGT_W-1:0]  hgt_t;

  localparam hgt_t HGT_NEG1 = '1;
  localparam hgt_t HGT_ONE  = hgt_t'(1);

  // command codes
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PEEK  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFREE  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOTUSED = 2'd2;

  // token that walks the cell chain, once as a lookup and once as an update
  typedef struct packed {
    logic  valid;
    logic  upd;         // 0 lookup pass, 1 update pass
    slot_t layer;       // slot operated on
    logic  hit;         // lookup: slot found and in use
    hgt_t  old_h;       // lookup: height of that slot
    logic  free_found;  // lookup: a free slot was seen
    slot_t free_idx;    // lowest free slot
    logic  shift_en;    // update: move heights inside lo..hi by one
    logic  inc;         // update: 1 raise, 0 lower
    hgt_t  lo;
    hgt_t  hi;
    logic  tgt_move;    // update: put the slot at tgt_h
    hgt_t  tgt_h;
    logic  tgt_free;    // update: release the slot
    logic  alloc;       // update: claim free_idx
  } lsord_tok_t;

endpackage

// ===== rtl/lsord_cell.sv =====
// one cell of the chain: state of a single layer slot
`timescale 1ns / 1ps

module lsord_cell
  import lsord_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  lsord_tok_t tok_in,
  output lsord_tok_t tok_out
);

  localparam slot_t MY_IDX = slot_t'(IDX);

  logic       in_use;
  logic       in_use_next;
  hgt_t       height;
  hgt_t       height_next;
  lsord_tok_t tok_next;

  // act on the passing token
  always_comb begin
    tok_next    = tok_in;
    in_use_next = in_use;
    height_next = height;
    if (tok_in.valid && !tok_in.upd) begin
      // lookup: report this slot if asked, and the first free slot
      if (tok_in.layer == MY_IDX) begin
        tok_next.hit   = in_use;
        tok_next.old_h = height;
      end
      if (!tok_in.free_found && !in_use) begin
        tok_next.free_found = 1'b1;
        tok_next.free_idx   = MY_IDX;
      end
    end
    if (tok_in.valid && tok_in.upd) begin
      // update: shift neighbors in range, then apply target changes
      if (tok_in.shift_en && (height >= tok_in.lo) && (height <= tok_in.hi)) begin
        height_next = tok_in.inc ? (height + HGT_ONE) : (height - HGT_ONE);
      end
      if (tok_in.tgt_move && (tok_in.layer == MY_IDX)) begin
        height_next = tok_in.tgt_h;
      end
      if (tok_in.tgt_free && (tok_in.layer == MY_IDX)) begin
        in_use_next = 1'b0;
      end
      if (tok_in.alloc && (tok_in.free_idx == MY_IDX)) begin
        in_use_next = 1'b1;
        height_next = HGT_NEG1;
      end
    end
  end

  // slot state and token stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use  <= 1'b0;
      height  <= HGT_NEG1;
      tok_out <= '0;
    end else begin
      in_use  <= in_use_next;
      height  <= height_next;
      tok_out <= tok_next;
    end
  end

endmodule

// ===== rtl/lsord_chain.sv =====
// row of slot cells, the token steps one cell per cycle
`timescale 1ns / 1ps

module lsord_chain
  import lsord_pkg::*;
#(
  parameter int LAYERS = LAYERS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  lsord_tok_t tok_in,
  output lsord_tok_t tok_out
);

  lsord_tok_t link [LAYERS+1];

  assign link[0] = tok_in;

  // cell i holds slot i
  for (genvar i = 0; i < LAYERS; i++) begin : g_cell
    lsord_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (link[i]),
      .tok_out (link[i+1])
    );
  end

  assign tok_out = link[LAYERS];

endmodule

// ===== rtl/layer_stack_order_core.sv =====
// Layer stack order: from input beat to result valid the token walks the
// LAYERS-cell chain once to look up, then once to update; a new command is
// taken only after both passes of the last. A finished result waits in the
// output register while a new command is taken; if that register is still
// full, it waits in ST_HOLD and no command is taken. Synchronous reset frees
// every slot, hides every layer and empties the stack; no clearing pass.
`timescale 1ns / 1ps

module layer_stack_order_core
  import lsord_pkg::*;
#(
  parameter int LAYERS = LAYERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: mode[1:0], layer[9:2], requested_height[18:10], zero fill
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: status[1:0], slot[9:2], final_height[18:10], visible_count[27:19]
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_QUERY  = 3'd1;
  localparam logic [2:0] ST_CALC   = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_HOLD   = 3'd4;

  logic [2:0]              state;
  logic [MODE_W-1:0]       mode_r;
  logic [LAYER_W-1:0]      layer_r;
  logic signed [REQ_W-1:0] req_r;
  hgt_t                    top;
  lsord_tok_t              q_tok;
  lsord_tok_t              chain_in;
  lsord_tok_t              chain_out;
  lsord_tok_t              upd_tok;
  lsord_tok_t              look_tok;

  logic [STATUS_W-1:0]     res_status;
  logic [LAYER_W-1:0]      res_slot;
  logic [FH_W-1:0]         res_fh;
  logic [VIS_W-1:0]        res_vis;

  logic [STATUS_W-1:0]     c_status;
  logic [LAYER_W-1:0]      c_slot;
  hgt_t                    c_fh;
  hgt_t                    c_top;
  hgt_t                    c_vis;
  hgt_t                    h_req;
  hgt_t                    h_clip;
  hgt_t                    h_vis;
  hgt_t                    h_eff;
  hgt_t                    mv_h;
  hgt_t                    top_p1;
  logic                    do_move;

  logic in_beat;
  logic out_free;
  logic exit_beat;

  assign in_beat   = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign exit_beat = chain_out.valid;

  // lookup token built from the incoming beat
  always_comb begin
    look_tok          = '0;
    look_tok.valid    = 1'b1;
    look_tok.upd      = 1'b0;
    look_tok.layer    = slot_t'(s_tdata[MODE_W +: LAYER_W]);
    look_tok.old_h    = HGT_NEG1;
  end

  // work out the update from the lookup result
  always_comb begin
    top_p1 = top + HGT_ONE;
    h_req  = hgt_t'(req_r);
    h_clip = (h_req > top_p1) ? top_p1 : h_req;
    h_vis  = (!q_tok.old_h[HGT_W-1] && (h_clip > top)) ? top : h_clip;
    h_eff  = (h_vis < HGT_NEG1) ? HGT_NEG1 : h_vis;
    mv_h   = (mode_r == MODE_SET) ? h_eff : HGT_NEG1;

    upd_tok          = '0;
    upd_tok.valid    = 1'b1;
    upd_tok.upd      = 1'b1;
    upd_tok.layer    = slot_t'(layer_r);
    upd_tok.free_idx = q_tok.free_idx;
    upd_tok.tgt_h    = mv_h;

    c_status = STAT_OK;
    c_slot   = layer_r;
    c_fh     = HGT_NEG1;
    c_top    = top;
    do_move  = 1'b0;

    unique case (mode_r)
      MODE_ALLOC: begin
        if (q_tok.free_found) begin
          upd_tok.alloc = 1'b1;
          c_slot        = q_tok.free_idx[LAYER_W-1:0];
        end else begin
          c_status = STAT_NOFREE;
          c_slot   = '0;
        end
      end
      MODE_SET: begin
        if (q_tok.hit) begin
          do_move = (q_tok.old_h != mv_h);
          c_fh    = h_eff;
        end else begin
          c_status = STAT_NOTUSED;
        end
      end
      MODE_FREE: begin
        if (q_tok.hit) begin
          do_move          = (q_tok.old_h != mv_h);
          upd_tok.tgt_free = 1'b1;
        end else begin
          c_status = STAT_NOTUSED;
        end
      end
      MODE_PEEK: begin
        if (q_tok.hit) begin
          c_fh = q_tok.old_h;
        end else begin
          c_status = STAT_NOTUSED;
        end
      end
    endcase

    // pick the band of neighbors that shifts by one
    if (do_move) begin
      upd_tok.tgt_move = 1'b1;
      upd_tok.shift_en = 1'b1;
      if (q_tok.old_h > mv_h) begin
        if (!mv_h[HGT_W-1]) begin
          upd_tok.lo  = mv_h;
          upd_tok.hi  = q_tok.old_h - HGT_ONE;
          upd_tok.inc = 1'b1;
        end else begin
          upd_tok.lo  = q_tok.old_h + HGT_ONE;
          upd_tok.hi  = top;
          upd_tok.inc = 1'b0;
          c_top       = top - HGT_ONE;
        end
      end else begin
        if (!q_tok.old_h[HGT_W-1]) begin
          upd_tok.lo  = q_tok.old_h + HGT_ONE;
          upd_tok.hi  = mv_h;
          upd_tok.inc = 1'b0;
        end else begin
          upd_tok.lo  = mv_h;
          upd_tok.hi  = top;
          upd_tok.inc = 1'b1;
          c_top       = top + HGT_ONE;
        end
      end
    end
    c_vis = c_top + HGT_ONE;
  end

  // token into the first cell
  always_comb begin
    chain_in = '0;
    if (state == ST_IDLE && in_beat) begin
      chain_in = look_tok;
    end else if (state == ST_CALC) begin
      chain_in = upd_tok;
    end
  end

  lsord_chain #(
    .LAYERS (LAYERS)
  ) u_chain (
    .clk     (clk),
    .rst     (rst),
    .tok_in  (chain_in),
    .tok_out (chain_out)
  );

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      top   <= HGT_NEG1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_beat) begin
            state <= ST_QUERY;
          end
        end
        ST_QUERY: begin
          if (exit_beat) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          top   <= c_top;
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (exit_beat) begin
            state <= out_free ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // command and lookup capture, result staging
  always_ff @(posedge clk) begin
    if (in_beat) begin
      mode_r  <= s_tdata[0 +: MODE_W];
      layer_r <= s_tdata[MODE_W +: LAYER_W];
      req_r   <= s_tdata[MODE_W+LAYER_W +: REQ_W];
    end
    if (state == ST_QUERY && exit_beat) begin
      q_tok <= chain_out;
    end
    if (state == ST_CALC) begin
      res_status <= c_status;
      res_slot   <= c_slot;
      res_fh     <= c_fh[FH_W-1:0];
      res_vis    <= c_vis[VIS_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (((state == ST_UPDATE && exit_beat) || state == ST_HOLD) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (((state == ST_UPDATE && exit_beat) || state == ST_HOLD) && out_free) begin
      m_tdata <= {{(M_TDATA_W-RES_BITS){1'b0}}, res_vis, res_fh, res_slot, res_status};
    end
  end

`ifndef NO_ASSERTIONS
  // a token leaves the chain only while the sequencer waits for it
  a_exit_state: assert property (@(posedge clk) disable iff (rst)
    chain_out.valid |-> (state == ST_QUERY || state == ST_UPDATE))
    else $error("token left chain outside a pass");

  // the kind of token leaving matches the pass in progress
  a_exit_kind: assert property (@(posedge clk) disable iff (rst)
    chain_out.valid |-> (chain_out.upd == (state == ST_UPDATE)))
    else $error("token kind does not match pass");

  // stack top stays inside the pool
  a_top_range: assert property (@(posedge clk) disable iff (rst)
    (top >= HGT_NEG1) && (top < hgt_t'(LAYERS)))
    else $error("stack top out of range");

  // a failed allocate reports slot zero and hidden
  a_nofree: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0 +: STATUS_W] == STAT_NOFREE) |->
      (m_tdata[STATUS_W +: LAYER_W] == '0 && m_tdata[STATUS_W+LAYER_W +: FH_W] == '1))
    else $error("failed allocate result malformed");

  // top moves only when the update is launched
  a_top_hold: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CALC) |=> $stable(top))
    else $error("stack top changed outside update launch");
`endif

endmodule

// ===== tb/sv/tb_layer_stack_order_core.sv =====
// testbench for the layer stack order core: directed and random commands checked by a scoreboard
`timescale 1ns / 1ps

module tb_layer_stack_order_core;
  import lsord_pkg::*;

  localparam int POOL        = 256;
  localparam int LATENCY     = 2 * POOL + 2;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int HOLD_CYCLES = 3000;

  // one reply beat split into its fields
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [LAYER_W-1:0]     slot;
    logic signed [FH_W-1:0] final_height;
    logic [VIS_W-1:0]       visible_count;
  } reply_t;

  // slot pool and z-order stack tracker, with the queue of replies still owed
  class stack_order_tracker;
    bit     in_use[POOL];
    int     height[POOL];
    int     entry[POOL];
    int     top_pos;
    int     used_count;
    int     errors;
    reply_t expected_replies[$];

    function new();
      int i;
      for (i = 0; i < POOL; i++) begin
        in_use[i] = 1'b0;
        height[i] = -1;
        entry[i]  = 0;
      end
      top_pos    = -1;
      used_count = 0;
      errors     = 0;
    endfunction

    function void set_entry(int pos, int s);
      entry[pos] = s;
      height[s]  = pos;
    endfunction

    // move slot s to stack position h, shifting the others to fit
    function void move_layer(int s, int h);
      int old_h;
      int p;
      old_h = height[s];
      if (h > top_pos + 1) h = top_pos + 1;
      // a visible layer can go no higher than the current top
      if (old_h >= 0 && h > top_pos) h = top_pos;
      if (h < -1) h = -1;
      if (old_h > h) begin
        if (h >= 0) begin
          for (p = old_h; p > h; p--) set_entry(p, entry[p-1]);
          set_entry(h, s);
        end else begin
          for (p = old_h; p < top_pos; p++) set_entry(p, entry[p+1]);
          top_pos--;
          height[s] = -1;
        end
      end else if (old_h < h) begin
        if (old_h >= 0) begin
          // raise starts at the old position, lower entries stay put
          for (p = old_h; p < h; p++) set_entry(p, entry[p+1]);
          set_entry(h, s);
        end else begin
          for (p = top_pos; p >= h; p--) set_entry(p + 1, entry[p]);
          set_entry(h, s);
          top_pos++;
        end
      end
    endfunction

    // apply an accepted command beat and queue the reply it owes
    function void note_command(logic [MODE_W-1:0] mode, logic [LAYER_W-1:0] layer,
                               logic signed [REQ_W-1:0] req);
      reply_t r;
      int     s;
      int     i;
      bit     found;
      s              = int'(layer);
      r.status       = STAT_OK;
      r.slot         = layer;
      r.final_height = '1;
      if (mode == MODE_ALLOC) begin
        r.status = STAT_NOFREE;
        r.slot   = '0;
        found    = 1'b0;
        for (i = 0; i < POOL; i++) begin
          if (!found && !in_use[i]) begin
            found     = 1'b1;
            in_use[i] = 1'b1;
            height[i] = -1;
            used_count++;
            r.status  = STAT_OK;
            r.slot    = LAYER_W'(i);
          end
        end
      end else if (!in_use[s]) begin
        r.status = STAT_NOTUSED;
      end else if (mode == MODE_SET) begin
        move_layer(s, int'(req));
        r.final_height = FH_W'(height[s]);
      end else if (mode == MODE_FREE) begin
        if (height[s] >= 0) move_layer(s, -1);
        in_use[s] = 1'b0;
        used_count--;
      end else begin
        r.final_height = FH_W'(height[s]);
      end
      r.visible_count = VIS_W'(top_pos + 1);
      expected_replies.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // compare one reply beat with the oldest owed reply
    function void check_reply(logic [M_TDATA_W-1:0] data);
      reply_t got;
      reply_t want;
      got.status        = data[STATUS_W-1:0];
      got.slot          = data[STATUS_W +: LAYER_W];
      got.final_height  = data[STATUS_W+LAYER_W +: FH_W];
      got.visible_count = data[STATUS_W+LAYER_W+FH_W +: VIS_W];
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, got %h", $time, data);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        compare_field("status", int'(want.status), int'(got.status));
        compare_field("slot", int'(want.slot), int'(got.slot));
        compare_field("final_height", int'(want.final_height), int'(got.final_height));
        compare_field("visible_count", int'(want.visible_count), int'(got.visible_count));
      end
    endfunction

    // mostly a slot in use, now and then any slot
    function int pick_layer();
      int start;
      int k;
      start = $urandom_range(POOL - 1);
      if (used_count > 0 && $urandom_range(99) < 85) begin
        for (k = 0; k < POOL; k++) begin
          if (in_use[(start + k) % POOL]) return (start + k) % POOL;
        end
      end
      return start;
    endfunction

    // heights inside the legal range, its edges, hide, bottom, or anything
    function int pick_height();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return int'($urandom_range(top_pos + 2)) - 1;
      else if (roll < 62) return top_pos + 1;
      else if (roll < 70) return top_pos;
      else if (roll < 78) return -1;
      else if (roll < 84) return 0;
      else return int'($urandom_range(511)) - 256;
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  stack_order_tracker tracker = new();
  bit                 sender_calm;
  int                 replies_seen;
  int                 cycle_count;

  layer_stack_order_core #(.LAYERS(POOL)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // offer one command beat, after a random idle gap unless sender_calm is set, note it once accepted
  task automatic send_cmd(input logic [MODE_W-1:0] mode, input int layer, input int req);
    logic [LAYER_W-1:0]      layer_bits;
    logic signed [REQ_W-1:0] req_bits;
    layer_bits = LAYER_W'(layer);
    req_bits   = REQ_W'(req);
    if (!sender_calm) begin
      while ($urandom_range(99) < 33) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'({req_bits, layer_bits, mode});
    do @(posedge clk); while (!s_tready);
    tracker.note_command(mode, layer_bits, req_bits);
  endtask

  task automatic send_random(input int w_alloc, input int w_set, input int w_free);
    int                roll;
    logic [MODE_W-1:0] mode;
    roll = $urandom_range(99);
    if (roll < w_alloc) mode = MODE_ALLOC;
    else if (roll < w_alloc + w_set) mode = MODE_SET;
    else if (roll < w_alloc + w_set + w_free) mode = MODE_FREE;
    else mode = MODE_PEEK;
    send_cmd(mode, tracker.pick_layer(), tracker.pick_height());
  endtask

  // hold the input side until every owed reply is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (tracker.expected_replies.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // stimulus
  initial begin
    int n;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    sender_calm = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // commands on slots never allocated
    send_cmd(MODE_SET, 0, 0);
    send_cmd(MODE_FREE, 7, 3);
    send_cmd(MODE_PEEK, 255, 255);
    repeat (4) send_cmd(MODE_ALLOC, 0, 0);
    // show from hidden, requests far above the top and far below hidden
    send_cmd(MODE_SET, 0, 0);
    send_cmd(MODE_SET, 1, 255);
    send_cmd(MODE_SET, 2, -256);
    send_cmd(MODE_SET, 2, 0);
    send_cmd(MODE_SET, 3, 1);
    // visible layer asked above the top, then same height
    send_cmd(MODE_SET, 2, 255);
    send_cmd(MODE_SET, 2, 3);
    // lower, then raise a visible layer from the bottom
    send_cmd(MODE_SET, 2, 1);
    send_cmd(MODE_SET, 3, 2);
    // hide the top layer and a middle one
    send_cmd(MODE_SET, 1, -1);
    send_cmd(MODE_SET, 0, -5);
    send_cmd(MODE_PEEK, 3, 0);
    // free a visible and a hidden layer, then touch a freed slot
    send_cmd(MODE_FREE, 2, 0);
    send_cmd(MODE_FREE, 1, 0);
    send_cmd(MODE_SET, 1, 0);
    send_cmd(MODE_ALLOC, 255, -1);
    send_cmd(MODE_ALLOC, 128, -256);
    send_cmd(MODE_FREE, 255, 0);
    send_cmd(MODE_SET, 3, 0);

    // allocation-heavy mix
    for (n = 0; n < 350; n++) send_random(45, 35, 12);
    wait_drained();

    // fill the pool, then ask for more than it has
    while (tracker.used_count < POOL) send_random(100, 0, 0);
    repeat (6) send_random(100, 0, 0);

    // reorder-heavy mix on a full pool, with a stretch of back-to-back beats
    for (n = 0; n < 300; n++) begin
      sender_calm = (n >= 100 && n < 250);
      send_random(10, 70, 10);
    end
    sender_calm = 1'b0;
    wait_drained();

    // drain-heavy mix
    for (n = 0; n < 300; n++) send_random(10, 30, 55);

    s_tvalid <= 1'b0;
    while (tracker.expected_replies.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // reply side: random backpressure, one long hold-off, one stretch always ready
  initial begin
    int hold_left;
    bit held_once;
    m_tready     = 1'b0;
    hold_left    = 0;
    held_once    = 1'b0;
    replies_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        tracker.check_reply(m_tdata);
        replies_seen++;
      end
      if (!held_once && replies_seen == 150) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (replies_seen >= 500 && replies_seen < 700) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 33);
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
